>>> sv/fsc_pkg.sv
// Shared types and constants for the frame swap chain manager.
package fsc_pkg;

  // Width of one frame index as it travels on the ports and in the queues.
  localparam int FRAME_W        = 3;
  localparam int NUM_FRAMES_DEF = 6;

  // Stream payload widths.
  localparam int IN_TDATA_W   = 8;
  localparam int IN_TUSER_W   = 2;
  localparam int OUT_TDATA_W  = 8;
  localparam int OUT_TUSER_W  = 4;

  typedef logic [FRAME_W-1:0] frame_t;

  typedef enum logic [1:0] {
    ACT_GET     = 2'd0,
    ACT_RELEASE = 2'd1,
    ACT_PRESENT = 2'd2,
    ACT_RESET   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_TAKEN    = 2'd1,
    STAT_NONE     = 2'd2,
    STAT_OVERFLOW = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_SKIP  = 2'd1,
    ST_DRAIN = 2'd2,
    ST_DONE  = 2'd3
  } state_t;

  // Operation requested of one queue in a cycle.
  typedef struct packed {
    logic pop;
    logic push;
  } fifo_op_t;

  // Control handed to each cell of a queue.
  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctrl_t;

endpackage

>>> sv/frame_swap_chain_manager.sv
// Top level of the frame swap chain manager: action sequencer and two queues.
//
// Frame indices circulate between a free queue, a pending queue and one held
// frame given to the presenter. Each input beat (action in in_tuser, frame
// in in_tdata) yields exactly one output beat. A beat that moves one entry per
// queue (get from free, release, present without a skip) goes from idle to
// done; one that drops a second pending frame back to free passes the skip
// state on the way, and reset present passes the drain state, which empties
// the pending queue one entry a cycle until it sees it empty. Each queue is
// a row of cells that moves one entry per cycle. The next beat is accepted
// while the previous result still waits in the output register.
module frame_swap_chain_manager
  import fsc_pkg::*;
#(
  parameter int NUM_FRAMES = NUM_FRAMES_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [2:0] frame_in
  input  logic [IN_TUSER_W-1:0]  in_tuser,   // [1:0] action
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // [2:0] frame_out
  output logic [OUT_TUSER_W-1:0] out_tuser   // [0] frame_valid, [2:1] status, [3] skipped
);

  localparam int CNT_W = $clog2(NUM_FRAMES + 1);

  state_t state_r, state_nxt;

  fifo_op_t         free_op, pend_op;
  frame_t           free_push, free_head, pend_head;
  logic [CNT_W-1:0] free_cnt, pend_cnt;
  logic             free_full, pend_full;

  frame_t  held_index_r, held_index_nxt;
  logic    held_valid_r, held_valid_nxt;

  frame_t  fout_r, fout_nxt;
  logic    fvalid_r, fvalid_nxt;
  status_t status_r, status_nxt;
  logic    skipped_r, skipped_nxt;
  logic    drop_r, drop_nxt;

  logic                   out_valid_r, out_valid_nxt;
  logic [OUT_TDATA_W-1:0] out_data_r, out_data_nxt;
  logic [OUT_TUSER_W-1:0] out_user_r, out_user_nxt;

  logic    accept;
  logic    out_free;
  action_t action;
  frame_t  frame_in;

  assign in_tready = (state_r == ST_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;
  assign action    = action_t'(in_tuser[1:0]);
  assign frame_in  = in_tdata[FRAME_W-1:0];

  // Queues.
  fsc_chain #(.DEPTH(NUM_FRAMES), .FILL(1'b1)) u_free (
    .clk       (clk),
    .rst_n     (rst_n),
    .op        (free_op),
    .push_data (free_push),
    .head      (free_head),
    .count     (free_cnt),
    .full      (free_full)
  );

  fsc_chain #(.DEPTH(NUM_FRAMES), .FILL(1'b0)) u_pend (
    .clk       (clk),
    .rst_n     (rst_n),
    .op        (pend_op),
    .push_data (frame_in),
    .head      (pend_head),
    .count     (pend_cnt),
    .full      (pend_full)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_DONE;
          case (action)
            ACT_GET: begin
              if (free_cnt == '0 && pend_cnt > CNT_W'(1)) begin
                state_nxt = ST_SKIP;
              end
            end
            ACT_PRESENT: begin
              if (pend_cnt > CNT_W'(2)) begin
                state_nxt = ST_SKIP;
              end
            end
            ACT_RESET: state_nxt = ST_DRAIN;
            default:   state_nxt = ST_DONE;
          endcase
        end
      end
      ST_SKIP: state_nxt = ST_DONE;
      ST_DRAIN: begin
        if (pend_cnt == '0) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Queue operations, held frame and result fields.
  always_comb begin
    free_op        = '0;
    pend_op        = '0;
    free_push      = pend_head;
    held_index_nxt = held_index_r;
    held_valid_nxt = held_valid_r;
    fout_nxt       = fout_r;
    fvalid_nxt     = fvalid_r;
    status_nxt     = status_r;
    skipped_nxt    = skipped_r;
    drop_nxt       = drop_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_data_nxt   = out_data_r;
    out_user_nxt   = out_user_r;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          fout_nxt    = '0;
          fvalid_nxt  = 1'b0;
          status_nxt  = STAT_OK;
          skipped_nxt = 1'b0;
          drop_nxt    = 1'b0;
          case (action)
            ACT_GET: begin
              if (free_cnt != '0) begin
                free_op.pop = 1'b1;
                fout_nxt    = free_head;
                fvalid_nxt  = 1'b1;
              end else if (pend_cnt != '0) begin
                pend_op.pop = 1'b1;
                fout_nxt    = pend_head;
                fvalid_nxt  = 1'b1;
                status_nxt  = STAT_TAKEN;
              end else begin
                status_nxt  = STAT_NONE;
              end
            end
            ACT_RELEASE: begin
              if (pend_full) begin
                drop_nxt = 1'b1;
              end else begin
                pend_op.push = 1'b1;
              end
            end
            ACT_PRESENT: begin
              if (pend_cnt == '0) begin
                status_nxt = STAT_NONE;
              end else begin
                // The previously held frame goes back to free.
                free_push = held_index_r;
                if (held_valid_r) begin
                  if (free_full) begin
                    drop_nxt = 1'b1;
                  end else begin
                    free_op.push = 1'b1;
                  end
                end
                pend_op.pop    = 1'b1;
                held_index_nxt = pend_head;
                held_valid_nxt = 1'b1;
                fout_nxt       = pend_head;
                fvalid_nxt     = 1'b1;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_SKIP: begin
        // One more pending frame is recycled to free.
        pend_op.pop = 1'b1;
        skipped_nxt = 1'b1;
        if (free_full) begin
          drop_nxt = 1'b1;
        end else begin
          free_op.push = 1'b1;
        end
      end
      ST_DRAIN: begin
        if (pend_cnt != '0) begin
          pend_op.pop = 1'b1;
          if (free_full) begin
            drop_nxt = 1'b1;
          end else begin
            free_op.push = 1'b1;
          end
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = OUT_TDATA_W'(fout_r);
          out_user_nxt  = {skipped_r, (drop_r ? STAT_OVERFLOW : status_r), fvalid_r};
        end
      end
      default: begin
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      held_valid_r <= 1'b0;
      held_index_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      held_valid_r <= held_valid_nxt;
      held_index_r <= held_index_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Result payload registers.
  always_ff @(posedge clk) begin
    fout_r     <= fout_nxt;
    fvalid_r   <= fvalid_nxt;
    status_r   <= status_nxt;
    skipped_r  <= skipped_nxt;
    drop_r     <= drop_nxt;
    out_data_r <= out_data_nxt;
    out_user_r <= out_user_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

>>> sv/fsc_cell.sv
// One queue cell: holds one frame index and shifts it toward the head.
module fsc_cell
  import fsc_pkg::*;
#(
  parameter bit     HAS_RST = 1'b0,
  parameter frame_t RST_VAL = '0
) (
  input  logic       clk,
  input  logic       rst_n,
  input  cell_ctrl_t ctrl,
  input  frame_t     nbr_data,
  input  frame_t     push_data,
  output frame_t     data_q
);

  frame_t data_r;
  frame_t data_nxt;

  // A shift takes the neighbor's entry; a load takes the pushed entry.
  always_comb begin
    data_nxt = data_r;
    if (ctrl.load) begin
      data_nxt = push_data;
    end else if (ctrl.shift) begin
      data_nxt = nbr_data;
    end
  end

  generate
    if (HAS_RST) begin : g_rst
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          data_r <= RST_VAL;
        end else begin
          data_r <= data_nxt;
        end
      end
    end else begin : g_norst
      always_ff @(posedge clk) begin
        data_r <= data_nxt;
      end
    end
  endgenerate

  assign data_q = data_r;

endmodule

>>> sv/fsc_chain.sv
// Shift-register queue built as a row of cells, with its fill count.
module fsc_chain
  import fsc_pkg::*;
#(
  parameter int DEPTH = NUM_FRAMES_DEF,
  parameter bit FILL  = 1'b0,
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  fifo_op_t         op,
  input  frame_t           push_data,
  output frame_t           head,
  output logic [CNT_W-1:0] count,
  output logic             full
);

  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;
  frame_t           cell_q [DEPTH];

  // The entry below the count is written; a pop moves every cell one place
  // toward the head, so a simultaneous push lands one place lower.
  genvar i;
  generate
    for (i = 0; i < DEPTH; i++) begin : g_cell
      cell_ctrl_t ctrl;
      frame_t     nbr;
      logic       load;

      if (i == DEPTH - 1) begin : g_last
        assign nbr = '0;
      end else begin : g_mid
        assign nbr = cell_q[i+1];
      end

      assign load = op.push &&
                    (op.pop ? (cnt_r == CNT_W'(i + 1)) : (cnt_r == CNT_W'(i)));
      assign ctrl = cell_ctrl_t'({op.pop, load});

      fsc_cell #(
        .HAS_RST (FILL),
        .RST_VAL (FRAME_W'(i))
      ) u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .nbr_data  (nbr),
        .push_data (push_data),
        .data_q    (cell_q[i])
      );
    end
  endgenerate

  // Fill count.
  always_comb begin
    cnt_nxt = cnt_r + CNT_W'(op.push) - CNT_W'(op.pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= FILL ? CNT_W'(DEPTH) : '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  assign head  = cell_q[0];
  assign count = cnt_r;
  assign full  = (cnt_r == CNT_W'(DEPTH));

endmodule

>>> sv/fsc_checker.sv
// Port-level checks for the frame swap chain manager, bound to the top level.
module fsc_checker
  import fsc_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic [OUT_TUSER_W-1:0] out_tuser
);

  // A stalled result beat holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result beat changed while stalled");

  // The block works on one beat at a time.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted again while busy");

  // Without a frame the frame field reads zero.
  a_no_frame_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tdata == '0)
    else $error("frame_out nonzero without frame_valid");

  // A skip only happens when a frame was handed out.
  a_skip_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[3] |-> out_tuser[0])
    else $error("skipped set without a frame");

  // Status agrees with frame_valid for taken and nothing-available results.
  a_status_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser[2:1] == STAT_NONE || out_tuser[2:1] == STAT_TAKEN)
    |-> out_tuser[0] == (out_tuser[2:1] == STAT_TAKEN))
    else $error("status disagrees with frame_valid");

endmodule

bind frame_swap_chain_manager fsc_checker u_fsc_checker (.*);
